// File: src/mkpc_pkg.sv
// Shared types and constants for the multi-key press classifier.
`default_nettype none

package mkpc_pkg;

    // Register map: byte addresses of the configuration registers.
    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] REG_CONFIRM_TICKS = 4'h0;
    localparam logic [ADDR_W-1:0] REG_LONG_TICKS    = 4'h4;
    localparam logic [ADDR_W-1:0] REG_ACTIVE_LEVELS = 4'h8;

    localparam int unsigned DATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [15:0] CONFIRM_TICKS_RST = 16'd10;
    localparam logic [15:0] LONG_TICKS_RST    = 16'd100;
    localparam logic [7:0]  ACTIVE_LEVELS_RST = 8'h01;

    // Key codes.
    localparam logic [7:0] CODE_NONE      = 8'h00;
    localparam logic [7:0] CODE_LONG_BASE = 8'h81;

    typedef enum logic [1:0] {
        PH_RELEASED   = 2'd0,
        PH_CONFIRMING = 2'd1,
        PH_SHORT      = 2'd2,
        PH_LONG       = 2'd3
    } t_phase;

endpackage

`default_nettype wire

// File: src/multi_key_press_classifier.sv
// Top level of the multi-key press classifier: debounce, short and long press per key.
`default_nettype none

// Takes one scan beat (tick and raw key levels) per clock cycle while o_in_stall is low,
// and returns one key code beat for each scan, through the input register and then the
// result register. The scan of all keys, including the per-key 32-bit elapsed-time
// subtract and compare and the priority that stops at the lowest reporting key, is
// combinational between those two registers, which sets the rate of one scan per cycle
// while the output is not stalled. Keys above the reporting key keep their state for that
// scan. Configuration writes are meant for an idle block.
module multi_key_press_classifier #(
    parameter int unsigned NUM_KEYS = 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_in_valid,
    output      logic                         o_in_stall,
    input  wire logic [31:0]                  i_now_ms,
    input  wire logic [7:0]                   i_key_levels,

    output      logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    output      logic [7:0]                   o_key_code,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mkpc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mkpc_pkg::DATA_W-1:0]  pwdata,
    output      logic [mkpc_pkg::DATA_W-1:0]  prdata,
    output      logic                         pready
);

    import mkpc_pkg::*;

    // Configuration registers.
    logic [15:0] r_confirm_ticks;
    logic [15:0] r_long_ticks;
    logic [7:0]  r_active_levels;

    // Input register.
    logic        r_in_valid;
    logic [31:0] r_now;
    logic [7:0]  r_levels;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_key_code;

    // Per-key state.
    t_phase      r_phase [NUM_KEYS];
    logic [31:0] r_start [NUM_KEYS];

    t_phase      n_phase [NUM_KEYS];
    logic        n_start_we [NUM_KEYS];
    logic [7:0]  n_key_code;

    logic        advance;
    logic        in_accept;
    logic        cfg_write;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_key_code;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr)
            REG_CONFIRM_TICKS: prdata = {16'd0, r_confirm_ticks};
            REG_LONG_TICKS:    prdata = {16'd0, r_long_ticks};
            REG_ACTIVE_LEVELS: prdata = {24'd0, r_active_levels};
            default:           prdata = '0;
        endcase
    end

    // Scan of all keys. Each key works out its own next phase and code; a key only
    // commits when no lower key reports a code in the same scan.
    always_comb begin
        logic        found;
        logic        down;
        logic [31:0] elapsed;
        t_phase      ph;
        logic        we;
        logic [7:0]  code;
        found      = 1'b0;
        n_key_code = CODE_NONE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            down    = (r_levels[k] == r_active_levels[k]);
            elapsed = r_now - r_start[k];
            ph      = r_phase[k];
            we      = 1'b0;
            code    = CODE_NONE;
            unique case (r_phase[k])
                PH_RELEASED: begin
                    if (down) begin
                        ph = PH_CONFIRMING;
                        we = 1'b1;
                    end
                end
                PH_CONFIRMING: begin
                    if (!down) begin
                        ph = PH_RELEASED;
                    end else if (elapsed >= {16'd0, r_confirm_ticks}) begin
                        ph = PH_SHORT;
                        we = 1'b1;
                    end
                end
                PH_SHORT: begin
                    if (!down) begin
                        ph   = PH_RELEASED;
                        code = 8'(k + 1);
                    end else if (elapsed >= {16'd0, r_long_ticks}) begin
                        ph = PH_LONG;
                    end
                end
                PH_LONG: begin
                    if (!down) begin
                        ph   = PH_RELEASED;
                        code = 8'(k) + CODE_LONG_BASE;
                    end
                end
                default: ph = PH_RELEASED;
            endcase
            if (found) begin
                n_phase[k]    = r_phase[k];
                n_start_we[k] = 1'b0;
            end else begin
                n_phase[k]    = ph;
                n_start_we[k] = we;
                if (code != CODE_NONE) begin
                    found      = 1'b1;
                    n_key_code = code;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_ticks <= CONFIRM_TICKS_RST;
            r_long_ticks    <= LONG_TICKS_RST;
            r_active_levels <= ACTIVE_LEVELS_RST;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_phase[k] <= PH_RELEASED;
            end
        end else begin
            if (cfg_write) begin
                if (paddr == REG_CONFIRM_TICKS) begin
                    r_confirm_ticks <= pwdata[15:0];
                end
                if (paddr == REG_LONG_TICKS) begin
                    r_long_ticks <= pwdata[15:0];
                end
                if (paddr == REG_ACTIVE_LEVELS) begin
                    r_active_levels <= pwdata[7:0];
                end
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    r_phase[k] <= n_phase[k];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_now    <= i_now_ms;
            r_levels <= i_key_levels;
        end
        if (advance) begin
            r_key_code <= n_key_code;
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (n_start_we[k]) begin
                    r_start[k] <= r_now;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A reported code always names an existing key.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_code != CODE_NONE) |->
            (o_key_code[6:0] != 7'd0 && 32'(o_key_code[6:0]) <= NUM_KEYS))
        else $error("key code names no key");

    // A scan held back by a stalled result keeps its tick.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_now)))
        else $error("held scan lost");

    // A key never skips debounce on its way to a press.
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_phase_chk
        a_no_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_phase[g] == PH_RELEASED) |=>
                (r_phase[g] == PH_RELEASED || r_phase[g] == PH_CONFIRMING))
            else $error("key left released without debounce");
    end
`endif

endmodule

`default_nettype wire

// File: dv/tb_multi_key_press_classifier.sv
// Testbench for the multi-key press classifier: directed and random scans checked against a local predictor.
`default_nettype none

module tb_multi_key_press_classifier;
    import mkpc_pkg::*;

    localparam int unsigned NUM_KEYS   = 3;
    localparam int          IDLE_LIMIT = 2000;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BLOCKS
    } t_rx_mode;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic [31:0]       i_now_ms     = '0;
    logic [7:0]        i_key_levels = '0;
    logic              i_out_stall  = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [7:0]        o_key_code;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    multi_key_press_classifier #(.NUM_KEYS(NUM_KEYS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_now_ms     (i_now_ms),
        .i_key_levels (i_key_levels),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_code   (o_key_code),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state and its copy of the registers.
    t_phase      key_phase_q [NUM_KEYS];
    logic [31:0] press_t_q   [NUM_KEYS];
    logic [15:0] cfg_confirm;
    logic [15:0] cfg_long;
    logic [7:0]  cfg_active;

    logic [7:0]  expected_codes [$];
    int          fail_count    = 0;
    logic [31:0] tick_now      = '0;
    int          burst_left    = 0;
    bit          sender_steady = 1'b0;
    logic [15:0] rx_cycle      = '0;
    int          idle_cycles   = 0;

    function automatic logic [7:0] classify_scan(input logic [31:0] now,
                                                 input logic [7:0] levels);
        logic [7:0]  code;
        logic        down;
        logic [31:0] elapsed;
        code = CODE_NONE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            // Keys above the first one that reports keep their state.
            if (code == CODE_NONE) begin
                down    = (levels[k] == cfg_active[k]);
                elapsed = now - press_t_q[k];
                case (key_phase_q[k])
                    PH_RELEASED: begin
                        if (down) begin
                            key_phase_q[k] = PH_CONFIRMING;
                            press_t_q[k]   = now;
                        end
                    end
                    PH_CONFIRMING: begin
                        if (!down) begin
                            key_phase_q[k] = PH_RELEASED;
                        end else if (elapsed >= {16'h0, cfg_confirm}) begin
                            key_phase_q[k] = PH_SHORT;
                            press_t_q[k]   = now;
                        end
                    end
                    PH_SHORT: begin
                        if (!down) begin
                            key_phase_q[k] = PH_RELEASED;
                            code           = 8'(k + 1);
                        end else if (elapsed >= {16'h0, cfg_long}) begin
                            key_phase_q[k] = PH_LONG;
                        end
                    end
                    default: begin
                        if (!down) begin
                            key_phase_q[k] = PH_RELEASED;
                            code           = CODE_LONG_BASE + 8'(k);
                        end
                    end
                endcase
            end
        end
        return code;
    endfunction

    // Pin levels for a set of pressed keys under the current active levels.
    function automatic logic [7:0] levels_for(input logic [2:0] pressed);
        logic [7:0] lv;
        lv      = cfg_active ^ ~{5'b0, pressed};
        lv[7:3] = 5'($urandom);
        return lv;
    endfunction

    // Result check and expectation capture, both on the values seen at the edge.
    always @(posedge i_clk) begin : scoreboard
        logic [7:0] want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_codes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected key code beat: %02h", o_key_code);
                end else begin
                    want = expected_codes.pop_front();
                    if (o_key_code !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("key_code mismatch: expected %02h, got %02h",
                                     want, o_key_code);
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                expected_codes.push_back(classify_scan(i_now_ms, i_key_levels));
        end
    end

    // The receiver cycles through free, random, periodic and blocked stretches.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        case (t_rx_mode'(rx_cycle[8:7]))
            RX_FREE:     i_out_stall <= 1'b0;
            RX_RANDOM:   i_out_stall <= ($urandom_range(0, 9) < 3);
            RX_PERIODIC: i_out_stall <= (rx_cycle[2:0] == 3'd5) || (rx_cycle[2:0] == 3'd6);
            default:     i_out_stall <= (rx_cycle[4:0] < 5'd9);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pwrite && pready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_scan(input logic [31:0] now, input logic [7:0] levels);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = sender_steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_now_ms     <= now;
        i_key_levels <= levels;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic press_scan(input logic [2:0] pressed, input logic [31:0] delta);
        tick_now += delta;
        send_scan(tick_now, levels_for(pressed));
    endtask

    task automatic raw_scan(input logic [7:0] levels, input logic [31:0] delta);
        tick_now += delta;
        send_scan(tick_now, levels);
    endtask

    // Stop sending and wait until every scan has its key code back.
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [15:0] value);
        logic [DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        // Junk above the register width must be dropped by the block.
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // Read the register back at the same address.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        want = (addr == REG_ACTIVE_LEVELS) ? {24'h0, value[7:0]} : {16'h0, value};
        if (prdata !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("register read mismatch at %h: expected %08h, got %08h",
                         addr, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_CONFIRM_TICKS: cfg_confirm = value;
            REG_LONG_TICKS:    cfg_long    = value;
            REG_ACTIVE_LEVELS: cfg_active  = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] confirm, input logic [15:0] long_t,
                              input logic [7:0] active);
        drain();
        apb_write(REG_CONFIRM_TICKS, confirm);
        apb_write(REG_LONG_TICKS, long_t);
        apb_write(REG_ACTIVE_LEVELS, {8'h0, active});
    endtask

    // Reset registers: debounce, short press, and a bounce back to released.
    task automatic test_short_press;
        tick_now = '0;
        press_scan(3'b001, 32'd0);
        press_scan(3'b001, 32'd9);
        press_scan(3'b001, 32'd1);
        press_scan(3'b000, 32'd50);
        press_scan(3'b001, 32'd1);
        press_scan(3'b000, 32'd1);
    endtask

    // Long press across the tick wrap, held through a huge jump.
    task automatic test_long_press_wrap;
        tick_now = 32'hFFFF_FFFF;
        press_scan(3'b100, 32'd0);
        press_scan(3'b100, 32'd10);
        press_scan(3'b100, 32'd100);
        press_scan(3'b100, 32'hFFFF_FF00);
        press_scan(3'b000, 32'd1);
    endtask

    // Zero thresholds; several keys report together and come out lowest first.
    task automatic test_priority;
        set_config(16'd0, 16'd0, 8'hFF);
        raw_scan(8'hFF, 32'd0);
        raw_scan(8'hFF, 32'd0);
        raw_scan(8'h00, 32'd1);
        raw_scan(8'h00, 32'd0);
        raw_scan(8'h00, 32'd0);
        raw_scan(8'h00, 32'd0);
        press_scan(3'b011, 32'd3);
        press_scan(3'b011, 32'd0);
        press_scan(3'b011, 32'd0);
        press_scan(3'b000, 32'd0);
        press_scan(3'b000, 32'd0);
    endtask

    // Largest thresholds; a backward tick step reads as a very long hold.
    task automatic test_backward_jump;
        set_config(16'hFFFF, 16'hFFFF, 8'h00);
        press_scan(3'b010, 32'd5);
        press_scan(3'b010, 32'hFFFF_FFFF);
        press_scan(3'b010, 32'hFFFF_FFFF);
        press_scan(3'b000, 32'd2);
    endtask

    task automatic test_random_phase(input logic [15:0] confirm, input logic [15:0] long_t,
                                     input logic [7:0] active, input int n_scans);
        int          sent_here;
        int          holds;
        logic [2:0]  mask;
        logic [31:0] span;
        set_config(confirm, long_t, active);
        tick_now  = $urandom;
        sent_here = 0;
        span      = {16'h0, cfg_confirm} / 4 + {16'h0, cfg_long} / 4 + 32'd3;
        while (sent_here < n_scans) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    raw_scan(8'($urandom), $urandom_range(0, span));
                    sent_here++;
                end
            end else begin
                mask  = 3'($urandom_range(1, 7));
                holds = $urandom_range(1, 10);
                repeat (holds) begin
                    // Now and then a key bounces open for one beat.
                    press_scan(($urandom_range(0, 9) == 0) ? (mask & 3'($urandom)) : mask,
                               ($urandom_range(0, 24) == 0) ? $urandom
                                                            : $urandom_range(0, span));
                    sent_here++;
                end
                // Up to three release beats so every reporting key gets its turn.
                repeat ($urandom_range(1, 3)) begin
                    press_scan(($urandom_range(0, 4) == 0) ? (mask & 3'($urandom)) : 3'b000,
                               $urandom_range(0, 3));
                    sent_here++;
                end
            end
        end
    endtask

    initial begin
        cfg_confirm = CONFIRM_TICKS_RST;
        cfg_long    = LONG_TICKS_RST;
        cfg_active  = ACTIVE_LEVELS_RST;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_phase_q[k] = PH_RELEASED;
            press_t_q[k]   = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_press();
        test_long_press_wrap();
        test_priority();
        test_backward_jump();
        test_random_phase(CONFIRM_TICKS_RST, LONG_TICKS_RST, ACTIVE_LEVELS_RST, 200);
        test_random_phase(16'd0, 16'd0, 8'hFF, 140);
        test_random_phase(16'hFFFF, 16'hFFFF, 8'h00, 140);
        test_random_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 300)),
                          8'($urandom), 220);
        test_random_phase(16'd3, 16'd20, 8'($urandom), 200);

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_codes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
